>>> sv/hsv_to_rgb_converter_macros.svh
// Assertion macros shared by the HSV to RGB converter modules.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HSVRGB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition in one cycle that implies an outcome in the following cycle.
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, cond, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) else $error(msg);

`endif

>>> sv/hsvrgb_pkg.sv
// Shared constants and pipeline stage types of the HSV to RGB converter.
package hsvrgb_pkg;

    // Channel format is unsigned Q1.12, hue is a fraction of a turn.
    localparam int ChFracBits = 12;
    localparam int ChW        = ChFracBits + 1;
    localparam int HueBits    = 16;
    localparam int SectorW    = 3;

    localparam logic [ChW-1:0]     ChOne  = {1'b1, {ChFracBits{1'b0}}};
    localparam logic [HueBits:0]   HueOne = {1'b1, {HueBits{1'b0}}};

    // Hue sextant; codes six and seven cannot arise from hue * 6.
    typedef enum logic [SectorW-1:0] {
        SECT_RED_YELLOW     = 3'd0,
        SECT_YELLOW_GREEN   = 3'd1,
        SECT_GREEN_CYAN     = 3'd2,
        SECT_CYAN_BLUE      = 3'd3,
        SECT_BLUE_MAGENTA   = 3'd4,
        SECT_MAGENTA_RED    = 3'd5
    } t_sector;

    // Raw pixel as taken from the input channel.
    typedef struct packed {
        logic [HueBits-1:0] hue;
        logic [ChW-1:0]     sat;
        logic [ChW-1:0]     val;
        logic [ChW-1:0]     alpha;
    } t_hsv;

    // After stage one: sector split and clamped channels.
    typedef struct packed {
        t_sector            sector;
        logic [HueBits-1:0] frac;
        logic               gray;
        logic [ChW-1:0]     sat;
        logic [ChW-1:0]     val;
        logic [ChW-1:0]     alpha;
    } t_stage1;

    // After stage two: saturation scaled by the fraction and its complement.
    typedef struct packed {
        t_sector        sector;
        logic           gray;
        logic [ChW-1:0] sat;
        logic [ChW-1:0] val;
        logic [ChW-1:0] alpha;
        logic [ChW-1:0] sf;
        logic [ChW-1:0] sfc;
    } t_stage2;

    // After stage three: the three derived levels.
    typedef struct packed {
        t_sector        sector;
        logic           gray;
        logic [ChW-1:0] val;
        logic [ChW-1:0] alpha;
        logic [ChW-1:0] lvl_p;
        logic [ChW-1:0] lvl_q;
        logic [ChW-1:0] lvl_t;
    } t_stage3;

    // Finished RGB pixel.
    typedef struct packed {
        logic [ChW-1:0] red;
        logic [ChW-1:0] green;
        logic [ChW-1:0] blue;
        logic [ChW-1:0] alpha;
    } t_rgb;

    // Advance enables of the two multiplier stages.
    typedef struct packed {
        logic s2;
        logic s3;
    } t_lvl_en;

    // Occupancy of the two multiplier stages.
    typedef struct packed {
        logic s2;
        logic s3;
    } t_lvl_vld;

endpackage

>>> sv/hsvrgb_sector.sv
// Stage one: hue to sector and fraction, saturation and value clamping.
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_sector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  hsvrgb_pkg::t_hsv    i_data,
    output logic                o_valid,
    output hsvrgb_pkg::t_stage1 o_data
);

    logic [hsvrgb_pkg::HueBits+2:0] n_h6;
    hsvrgb_pkg::t_stage1            n_stage;
    hsvrgb_pkg::t_stage1            r_stage;
    logic                           r_valid;

    // Hue times six as two shifted adds; the top bits are the sector.
    always_comb begin
        n_h6 = {i_data.hue, 2'b00} + {1'b0, i_data.hue, 1'b0};
        n_stage.sector = hsvrgb_pkg::t_sector'(n_h6[hsvrgb_pkg::HueBits+2:hsvrgb_pkg::HueBits]);
        n_stage.frac   = n_h6[hsvrgb_pkg::HueBits-1:0];
        n_stage.sat    = (i_data.sat > hsvrgb_pkg::ChOne) ? hsvrgb_pkg::ChOne : i_data.sat;
        n_stage.val    = (i_data.val > hsvrgb_pkg::ChOne) ? hsvrgb_pkg::ChOne : i_data.val;
        n_stage.gray   = (i_data.sat == '0);
        n_stage.alpha  = i_data.alpha;
    end

    // Valid bit of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_stage;

    `HSVRGB_ASSERT_NEXT(a_sector_clamped, i_clk, i_rst_n, i_en && i_valid, o_valid && (o_data.sat <= hsvrgb_pkg::ChOne) && (o_data.val <= hsvrgb_pkg::ChOne), "stage one lost a transaction or left a channel above one")
    `HSVRGB_ASSERT(a_sector_gray, i_clk, i_rst_n, o_valid |-> (o_data.gray == (o_data.sat == '0)), "gray flag disagrees with clamped saturation")

endmodule

>>> sv/hsvrgb_levels.sv
// Stages two and three: saturation products and the p, q and t levels.
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_levels (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hsvrgb_pkg::t_lvl_en  i_en,
    input  logic                 i_valid,
    input  hsvrgb_pkg::t_stage1  i_data,
    output hsvrgb_pkg::t_lvl_vld o_vld,
    output hsvrgb_pkg::t_stage3  o_data
);

    localparam int SfW  = hsvrgb_pkg::ChW + hsvrgb_pkg::HueBits;
    localparam int SfcW = SfW + 1;
    localparam int LvW  = 2 * hsvrgb_pkg::ChW;

    // v * (1 - x), truncated back to the channel format.
    function automatic logic [hsvrgb_pkg::ChW-1:0] scale_level(
        input logic [hsvrgb_pkg::ChW-1:0] v,
        input logic [hsvrgb_pkg::ChW-1:0] x
    );
        logic [LvW-1:0] prod;
        prod = LvW'(v) * LvW'(hsvrgb_pkg::ChOne - x);
        return prod[hsvrgb_pkg::ChFracBits+hsvrgb_pkg::ChW-1:hsvrgb_pkg::ChFracBits];
    endfunction

    logic [hsvrgb_pkg::HueBits:0] n_frac_c;
    logic [SfW-1:0]               n_sf_prod;
    logic [SfcW-1:0]              n_sfc_prod;
    hsvrgb_pkg::t_stage2          n_s2;
    hsvrgb_pkg::t_stage2          r_s2;
    hsvrgb_pkg::t_stage3          n_s3;
    hsvrgb_pkg::t_stage3          r_s3;
    logic                         r_vld2;
    logic                         r_vld3;
    logic [hsvrgb_pkg::ChW:0]     w_frac_sum;
    logic [hsvrgb_pkg::ChW:0]     w_sat_ext;

    // Stage two: s * f and s * (1 - f), both truncated.
    always_comb begin
        n_frac_c   = hsvrgb_pkg::HueOne - {1'b0, i_data.frac};
        n_sf_prod  = SfW'(i_data.sat) * SfW'(i_data.frac);
        n_sfc_prod = SfcW'(i_data.sat) * SfcW'(n_frac_c);
        n_s2.sector = i_data.sector;
        n_s2.gray   = i_data.gray;
        n_s2.sat    = i_data.sat;
        n_s2.val    = i_data.val;
        n_s2.alpha  = i_data.alpha;
        n_s2.sf     = n_sf_prod[SfW-1:hsvrgb_pkg::HueBits];
        n_s2.sfc    = n_sfc_prod[SfW-1:hsvrgb_pkg::HueBits];
    end

    // Stage three: the three levels from value.
    always_comb begin
        n_s3.sector = r_s2.sector;
        n_s3.gray   = r_s2.gray;
        n_s3.val    = r_s2.val;
        n_s3.alpha  = r_s2.alpha;
        n_s3.lvl_p  = scale_level(r_s2.val, r_s2.sat);
        n_s3.lvl_q  = scale_level(r_s2.val, r_s2.sf);
        n_s3.lvl_t  = scale_level(r_s2.val, r_s2.sfc);
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (i_en.s2) begin
                r_vld2 <= i_valid;
            end
            if (i_en.s3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (i_en.s2 && i_valid) begin
            r_s2 <= n_s2;
        end
        if (i_en.s3 && r_vld2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_vld.s2 = r_vld2;
    assign o_vld.s3 = r_vld3;
    assign o_data   = r_s3;

    // The two truncated products together fall short of s by at most one.
    assign w_frac_sum = {1'b0, r_s2.sf} + {1'b0, r_s2.sfc};
    assign w_sat_ext  = {1'b0, r_s2.sat};

    `HSVRGB_ASSERT(a_frac_split, i_clk, i_rst_n, r_vld2 |-> (w_frac_sum == w_sat_ext) || ((w_frac_sum + 1'b1) == w_sat_ext), "saturation products do not add up to saturation")
    `HSVRGB_ASSERT_NEXT(a_levels_bounded, i_clk, i_rst_n, i_en.s3 && r_vld2, r_vld3 && (r_s3.lvl_p <= r_s3.val) && (r_s3.lvl_q <= r_s3.val) && (r_s3.lvl_t <= r_s3.val), "a level exceeds value")

endmodule

>>> sv/hsvrgb_select.sv
// Stage four: sector placement of the levels into the output register.
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  hsvrgb_pkg::t_stage3 i_data,
    output logic                o_valid,
    output hsvrgb_pkg::t_rgb    o_data
);

    hsvrgb_pkg::t_rgb n_pix;
    hsvrgb_pkg::t_rgb r_pix;
    logic             r_valid;

    // Hexcone placement; zero saturation gives gray at value.
    always_comb begin
        n_pix.alpha = i_data.alpha;
        n_pix.red   = i_data.val;
        n_pix.green = i_data.val;
        n_pix.blue  = i_data.val;
        if (!i_data.gray) begin
            unique case (i_data.sector)
                hsvrgb_pkg::SECT_YELLOW_GREEN: begin
                    n_pix.red   = i_data.lvl_q;
                    n_pix.blue  = i_data.lvl_p;
                end
                hsvrgb_pkg::SECT_GREEN_CYAN: begin
                    n_pix.red   = i_data.lvl_p;
                    n_pix.blue  = i_data.lvl_t;
                end
                hsvrgb_pkg::SECT_CYAN_BLUE: begin
                    n_pix.red   = i_data.lvl_p;
                    n_pix.green = i_data.lvl_q;
                end
                hsvrgb_pkg::SECT_BLUE_MAGENTA: begin
                    n_pix.red   = i_data.lvl_t;
                    n_pix.green = i_data.lvl_p;
                end
                hsvrgb_pkg::SECT_MAGENTA_RED: begin
                    n_pix.green = i_data.lvl_p;
                    n_pix.blue  = i_data.lvl_q;
                end
                default: begin
                    n_pix.green = i_data.lvl_t;
                    n_pix.blue  = i_data.lvl_p;
                end
            endcase
        end
    end

    // Output valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_pix;

    `HSVRGB_ASSERT_NEXT(a_gray_out, i_clk, i_rst_n, i_en && i_valid && i_data.gray, o_valid && (o_data.red == o_data.green) && (o_data.green == o_data.blue), "gray pixel left with unequal channels")

endmodule

>>> sv/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB pixel converter.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_ready    i_hue, i_saturation, i_brightness, i_opacity
//   output    out        o_valid / i_ready    o_red, o_green, o_blue, o_opacity_out
//
// Four register stages: sector split, saturation products, level products, placement.
// Placement drives o_valid; one transaction per cycle is taken unless stalled.
// The multiplier stages set the depth: stage two forms two products of at most 13 by 17
// bits, stage three forms three 13 by 13 bit products.
// A stall on the output stops only the occupied stages; empty stages still fill.
// Synchronous active-low reset clears every valid bit; no payload is reset.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [hsvrgb_pkg::HueBits-1:0]  i_hue,
    input  logic [hsvrgb_pkg::ChW-1:0]      i_saturation,
    input  logic [hsvrgb_pkg::ChW-1:0]      i_brightness,
    input  logic [hsvrgb_pkg::ChW-1:0]      i_opacity,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [hsvrgb_pkg::ChW-1:0]      o_red,
    output logic [hsvrgb_pkg::ChW-1:0]      o_green,
    output logic [hsvrgb_pkg::ChW-1:0]      o_blue,
    output logic [hsvrgb_pkg::ChW-1:0]      o_opacity_out
);

    hsvrgb_pkg::t_hsv     w_hsv;
    hsvrgb_pkg::t_stage1  w_s1;
    hsvrgb_pkg::t_stage3  w_s3;
    hsvrgb_pkg::t_rgb     w_pix;
    hsvrgb_pkg::t_lvl_en  w_lvl_en;
    hsvrgb_pkg::t_lvl_vld w_lvl_vld;
    logic                 w_vld1;
    logic                 w_en1;
    logic                 w_en4;

    // A stage advances when it is empty or the stage after it advances.
    assign w_en4       = !o_valid || i_ready;
    assign w_lvl_en.s3 = !w_lvl_vld.s3 || w_en4;
    assign w_lvl_en.s2 = !w_lvl_vld.s2 || w_lvl_en.s3;
    assign w_en1       = !w_vld1 || w_lvl_en.s2;
    assign o_ready     = w_en1;

    assign w_hsv.hue   = i_hue;
    assign w_hsv.sat   = i_saturation;
    assign w_hsv.val   = i_brightness;
    assign w_hsv.alpha = i_opacity;

    hsvrgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en1),
        .i_valid (i_valid),
        .i_data  (w_hsv),
        .o_valid (w_vld1),
        .o_data  (w_s1)
    );

    hsvrgb_levels u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_lvl_en),
        .i_valid (w_vld1),
        .i_data  (w_s1),
        .o_vld   (w_lvl_vld),
        .o_data  (w_s3)
    );

    hsvrgb_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en4),
        .i_valid (w_lvl_vld.s3),
        .i_data  (w_s3),
        .o_valid (o_valid),
        .o_data  (w_pix)
    );

    assign o_red         = w_pix.red;
    assign o_green       = w_pix.green;
    assign o_blue        = w_pix.blue;
    assign o_opacity_out = w_pix.alpha;

    `HSVRGB_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !o_valid |-> o_ready, "input refused while the output register is empty")
    `HSVRGB_ASSERT_NEXT(a_output_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "waiting result dropped during a stall")

endmodule

>>> tb/sv/hsv_to_rgb_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel and compares the results.
module hsv_to_rgb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [hsvrgb_pkg::HueBits-1:0] i_hue,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_saturation,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_brightness,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_opacity,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_red,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_green,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_blue,
    input  logic [hsvrgb_pkg::ChW-1:0]     i_opacity_out,
    output int                             o_mismatches,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Pixels predicted from accepted input transactions, oldest first.
    hsvrgb_pkg::t_rgb expected_pixels[$];
    hsvrgb_pkg::t_rgb due_pixel;
    int               mismatch_total = 0;

    // Hexcone conversion in Q1.12 with truncating products.
    function automatic hsvrgb_pkg::t_rgb convert_pixel(
        input logic [hsvrgb_pkg::HueBits-1:0] hue,
        input logic [hsvrgb_pkg::ChW-1:0]     sat,
        input logic [hsvrgb_pkg::ChW-1:0]     val,
        input logic [hsvrgb_pkg::ChW-1:0]     alpha
    );
        logic [hsvrgb_pkg::ChW-1:0]     s_lvl;
        logic [hsvrgb_pkg::ChW-1:0]     v_lvl;
        logic [hsvrgb_pkg::ChW-1:0]     sat_frac;
        logic [hsvrgb_pkg::ChW-1:0]     sat_comp;
        logic [hsvrgb_pkg::ChW-1:0]     lvl_p;
        logic [hsvrgb_pkg::ChW-1:0]     lvl_q;
        logic [hsvrgb_pkg::ChW-1:0]     lvl_t;
        logic [hsvrgb_pkg::HueBits+2:0] hue6;
        logic [hsvrgb_pkg::HueBits-1:0] frac;
        hsvrgb_pkg::t_sector            sector;
        hsvrgb_pkg::t_rgb               px;
        s_lvl = (sat > hsvrgb_pkg::ChOne) ? hsvrgb_pkg::ChOne : sat;
        v_lvl = (val > hsvrgb_pkg::ChOne) ? hsvrgb_pkg::ChOne : val;
        px.red   = v_lvl;
        px.green = v_lvl;
        px.blue  = v_lvl;
        px.alpha = alpha;
        // Zero saturation leaves a gray at the brightness level.
        if (s_lvl != '0) begin
            hue6     = hue * 6;
            sector   = hsvrgb_pkg::t_sector'(hue6[hsvrgb_pkg::HueBits+2:hsvrgb_pkg::HueBits]);
            frac     = hue6[hsvrgb_pkg::HueBits-1:0];
            sat_frac = hsvrgb_pkg::ChW'((64'(s_lvl) * 64'(frac)) >> hsvrgb_pkg::HueBits);
            sat_comp = hsvrgb_pkg::ChW'((64'(s_lvl) * (64'(hsvrgb_pkg::HueOne) - 64'(frac)))
                                        >> hsvrgb_pkg::HueBits);
            lvl_p    = hsvrgb_pkg::ChW'((64'(v_lvl) * (64'(hsvrgb_pkg::ChOne) - 64'(s_lvl)))
                                        >> hsvrgb_pkg::ChFracBits);
            lvl_q    = hsvrgb_pkg::ChW'((64'(v_lvl) * (64'(hsvrgb_pkg::ChOne) - 64'(sat_frac)))
                                        >> hsvrgb_pkg::ChFracBits);
            lvl_t    = hsvrgb_pkg::ChW'((64'(v_lvl) * (64'(hsvrgb_pkg::ChOne) - 64'(sat_comp)))
                                        >> hsvrgb_pkg::ChFracBits);
            unique case (sector)
                hsvrgb_pkg::SECT_YELLOW_GREEN: begin
                    px.red = lvl_q; px.green = v_lvl; px.blue = lvl_p;
                end
                hsvrgb_pkg::SECT_GREEN_CYAN: begin
                    px.red = lvl_p; px.green = v_lvl; px.blue = lvl_t;
                end
                hsvrgb_pkg::SECT_CYAN_BLUE: begin
                    px.red = lvl_p; px.green = lvl_q; px.blue = v_lvl;
                end
                hsvrgb_pkg::SECT_BLUE_MAGENTA: begin
                    px.red = lvl_t; px.green = lvl_p; px.blue = v_lvl;
                end
                hsvrgb_pkg::SECT_MAGENTA_RED: begin
                    px.red = v_lvl; px.green = lvl_p; px.blue = lvl_q;
                end
                default: begin
                    px.red = v_lvl; px.green = lvl_t; px.blue = lvl_p;
                end
            endcase
        end
        return px;
    endfunction

    // Compare one channel of a result and report any difference.
    task automatic check_channel(input string label, input logic [hsvrgb_pkg::ChW-1:0] want,
                                 input logic [hsvrgb_pkg::ChW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatch_total++;
        end
    endtask

    // Predict on input transactions and check on output transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(convert_pixel(i_hue, i_saturation,
                                                        i_brightness, i_opacity));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0d %0d %0d %0d",
                             $time, i_red, i_green, i_blue, i_opacity_out);
                    mismatch_total++;
                end else begin
                    due_pixel = expected_pixels.pop_front();
                    check_channel("red", due_pixel.red, i_red);
                    check_channel("green", due_pixel.green, i_green);
                    check_channel("blue", due_pixel.blue, i_blue);
                    check_channel("opacity", due_pixel.alpha, i_opacity_out);
                end
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= expected_pixels.size();
    end

endmodule

>>> tb/sv/tb_hsv_to_rgb_converter.sv
// Testbench top for the HSV to RGB converter: stimulus, output stalls and the verdict.
module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomPixels = 1700;
    localparam int CycleLimit   = 200000;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_valid      = 1'b0;
    logic [hsvrgb_pkg::HueBits-1:0] i_hue        = '0;
    logic [hsvrgb_pkg::ChW-1:0]     i_saturation = '0;
    logic [hsvrgb_pkg::ChW-1:0]     i_brightness = '0;
    logic [hsvrgb_pkg::ChW-1:0]     i_opacity    = '0;
    logic                           i_ready      = 1'b0;
    logic                           o_ready;
    logic                           o_valid;
    logic [hsvrgb_pkg::ChW-1:0]     o_red;
    logic [hsvrgb_pkg::ChW-1:0]     o_green;
    logic [hsvrgb_pkg::ChW-1:0]     o_blue;
    logic [hsvrgb_pkg::ChW-1:0]     o_opacity_out;
    int                             mismatches;
    int                             pending;
    int                             cycle_count = 0;
    int                             stall_left  = 0;
    logic [9:0]                     rx_phase    = '0;

    hsv_to_rgb_converter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_opacity    (i_opacity),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_opacity_out(o_opacity_out)
    );

    hsv_to_rgb_checker pixel_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_opacity    (i_opacity),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .i_opacity_out(o_opacity_out),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Give up if the run takes far longer than the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb_hsv_to_rgb_converter: FAIL");
            $finish;
        end
    end

    // Output stalls: none while rx_phase[9:8] is 0 (a quarter), random runs elsewhere.
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase[9:8] == 2'b00) begin
            i_ready <= 1'b1;
        end else if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left <= $urandom_range(1, 10);
            end
        end
    end

    // Present one pixel and hold it until the transaction completes.
    task automatic send_pixel(input logic [hsvrgb_pkg::HueBits-1:0] hue,
                              input logic [hsvrgb_pkg::ChW-1:0] sat,
                              input logic [hsvrgb_pkg::ChW-1:0] val,
                              input logic [hsvrgb_pkg::ChW-1:0] alpha);
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        i_opacity    <= alpha;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Hold the input idle until every predicted pixel has come out.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Channel level biased towards zero, full scale and the clamped range.
    function automatic logic [hsvrgb_pkg::ChW-1:0] pick_level();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return '0;
        if (pick == 1) return hsvrgb_pkg::ChOne;
        if (pick == 2) return hsvrgb_pkg::ChW'($urandom_range(4097, 8191));
        return hsvrgb_pkg::ChW'($urandom_range(0, 4096));
    endfunction

    initial begin
        int gap;
        int burst;
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: gray, sector edges, full and clamped levels, opacity extremes.
        send_pixel(16'd0,     13'd0,    13'd4096, 13'd4096);
        send_pixel(16'd40000, 13'd0,    13'd1234, 13'd0);
        send_pixel(16'd0,     13'd4096, 13'd4096, 13'd8191);
        send_pixel(16'd10922, 13'd4096, 13'd4096, 13'd1);
        send_pixel(16'd10923, 13'd4096, 13'd4096, 13'd2048);
        send_pixel(16'd21845, 13'd4096, 13'd4096, 13'd4095);
        send_pixel(16'd21846, 13'd3000, 13'd4096, 13'd4097);
        send_pixel(16'd32767, 13'd3000, 13'd3500, 13'd100);
        send_pixel(16'd32768, 13'd3000, 13'd3500, 13'd200);
        send_pixel(16'd43690, 13'd2048, 13'd4000, 13'd300);
        send_pixel(16'd43691, 13'd2048, 13'd4000, 13'd400);
        send_pixel(16'd54613, 13'd1,    13'd4096, 13'd500);
        send_pixel(16'd54614, 13'd1,    13'd4096, 13'd600);
        send_pixel(16'd65535, 13'd4096, 13'd4096, 13'd700);
        send_pixel(16'd65535, 13'd8191, 13'd8191, 13'd8191);
        send_pixel(16'd5000,  13'd4097, 13'd2000, 13'd4096);
        send_pixel(16'd27000, 13'd2500, 13'd8191, 13'd0);
        send_pixel(16'd49000, 13'd4096, 13'd0,    13'd4096);
        send_pixel(16'd16384, 13'd8191, 13'd4097, 13'd6000);
        send_pixel(16'd60000, 13'd0,    13'd8191, 13'd7777);
        send_pixel(16'd38000, 13'd4095, 13'd4095, 13'd4095);
        drain_pipeline();

        // Random pixels in bursts; the first 100 of every 400 pixels run without gaps.
        sent = 0;
        while (sent < RandomPixels) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                send_pixel(hsvrgb_pkg::HueBits'($urandom_range(0, 65535)), pick_level(),
                           pick_level(), hsvrgb_pkg::ChW'($urandom_range(0, 8191)));
                sent++;
            end
            if (sent >= 800 && sent - burst < 800) begin
                drain_pipeline();
            end else begin
                if ((sent % 400) < 100 || $urandom_range(0, 3) == 0) gap = 0;
                else gap = $urandom_range(1, 6);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        // Let the last pixels out, then allow a few spare cycles for strays.
        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_hsv_to_rgb_converter: PASS");
        end else begin
            $display("tb_hsv_to_rgb_converter: FAIL");
        end
        $finish;
    end

endmodule
